/* rtl/core/overwrite_ring_queue_with_key_purge_core_macros.svh */
// Assertion macros shared by the ring queue RTL.
`ifndef OVERWRITE_RING_QUEUE_WITH_KEY_PURGE_CORE_MACROS_SVH
`define OVERWRITE_RING_QUEUE_WITH_KEY_PURGE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define ORQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ORQ_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ORQ_ASSERT(lbl, prop, msg)
`define ORQ_IMPLY(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/orq_pkg.sv */
// Shared constants, request codes and control types of the ring queue.
package orq_pkg;

  localparam int DEF_CAPACITY     = 16;
  localparam int DEF_PAYLOAD_BITS = 32;

  localparam int MODE_W = 3;
  localparam int KEY_W  = 32;
  localparam int PAY_W  = 32;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH  = 3'd0,
    MODE_POP   = 3'd1,
    MODE_FRONT = 3'd2,
    MODE_PEEK  = 3'd3,
    MODE_PURGE = 3'd4
  } mode_t;

  typedef struct packed {
    logic latch;
    logic push;
    logic rd_item;
    logic set_err;
    logic capture;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic emit;
  } orq_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              item_ok;
    logic              scan_more;
    logic              rd_pending;
  } orq_sts_t;

endpackage

/* rtl/core/orq_datapath.sv */
// Datapath of the ring queue: event memory, pointers, purge scan and result registers.
`include "overwrite_ring_queue_with_key_purge_core_macros.svh"
module orq_datapath #(
  parameter int CAPACITY     = orq_pkg::DEF_CAPACITY,
  parameter int PAYLOAD_BITS = orq_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  orq_pkg::orq_cmd_t           cmd,
  output orq_pkg::orq_sts_t           sts,
  input  logic [orq_pkg::MODE_W-1:0]  in_mode,
  input  logic [orq_pkg::KEY_W-1:0]   in_event_key,
  input  logic [orq_pkg::PAY_W-1:0]   in_event_payload,
  input  logic [orq_pkg::IDX_W-1:0]   in_peek_index,
  input  logic                        in_last_key,
  output logic                        out_status,
  output logic [orq_pkg::KEY_W-1:0]   out_key,
  output logic [orq_pkg::PAY_W-1:0]   out_payload,
  output logic [orq_pkg::CNT_W-1:0]   out_removed_total,
  output logic [orq_pkg::CNT_W-1:0]   out_fill_count
);
  import orq_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int SW    = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam int WW    = KEY_W + PAYLOAD_BITS;
  localparam int DEPTH = 2 ** (AW + 1);

  logic [MODE_W-1:0]       mode_r;
  logic [KEY_W-1:0]        key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    last_r;

  logic [AW-1:0] oldest_r;
  logic [CW-1:0] held_r;
  logic          bank_r;
  logic [CW-1:0] acc_r;
  logic [CW-1:0] scan_idx_r;
  logic [CW-1:0] kept_r;
  logic [CW-1:0] removed_r;
  logic          rd_vld_r;

  logic                    res_status_r;
  logic [KEY_W-1:0]        res_key_r;
  logic [PAYLOAD_BITS-1:0] res_pay_r;

  logic             out_status_r;
  logic [KEY_W-1:0] out_key_r;
  logic [PAY_W-1:0] out_pay_r;
  logic [CNT_W-1:0] out_total_r;
  logic [CNT_W-1:0] out_fill_r;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rdata_r;

  logic          full;
  logic [AW-1:0] oldest_inc;
  logic [AW-1:0] tail_slot;
  logic [AW-1:0] peek_slot;
  logic [AW-1:0] scan_slot;
  logic          scan_more;
  logic          item_ok;
  logic          key_match;
  logic          we;
  logic          re;
  logic [AW:0]   waddr;
  logic [AW:0]   raddr;
  logic [WW-1:0] wdata;
  logic [CW:0]   acc_sum;
  logic [CW-1:0] acc_sat;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [SW-1:0] ofs);
    logic [SW-1:0] sum;
    sum = SW'(base) + ofs;
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

  always_comb begin
    full       = (held_r == CW'(CAPACITY));
    oldest_inc = (oldest_r == AW'(CAPACITY - 1)) ? '0 : oldest_r + 1'b1;
    tail_slot  = full ? oldest_r : slot_of(oldest_r, SW'(held_r));
    peek_slot  = slot_of(oldest_r, SW'(idx_r));
    scan_slot  = slot_of(oldest_r, SW'(scan_idx_r));
    scan_more  = (scan_idx_r < held_r);
    key_match  = (rdata_r[WW-1 -: KEY_W] == key_r);
    unique case (mode_r)
      MODE_POP, MODE_FRONT: item_ok = (held_r != '0);
      MODE_PEEK:            item_ok = (SW'(idx_r) < SW'(held_r));
      default:              item_ok = 1'b0;
    endcase
    acc_sum = (CW + 1)'(acc_r) + (CW + 1)'(removed_r);
    acc_sat = (acc_sum > (CW + 1)'(CAPACITY)) ? CW'(CAPACITY) : acc_sum[CW-1:0];
  end

  // Push writes the live bank; a purge copies survivors into the other bank.
  always_comb begin
    we    = cmd.push | (rd_vld_r & ~key_match);
    waddr = cmd.push ? {bank_r, tail_slot} : {~bank_r, kept_r[AW-1:0]};
    wdata = cmd.push ? {key_r, pay_r} : rdata_r;
    re    = cmd.rd_item | (cmd.scan_step & scan_more);
    if (cmd.rd_item) begin
      raddr = {bank_r, (mode_r == MODE_PEEK) ? peek_slot : oldest_r};
    end else begin
      raddr = {bank_r, scan_slot};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r   <= '0;
      held_r     <= '0;
      bank_r     <= 1'b0;
      acc_r      <= '0;
      scan_idx_r <= '0;
      kept_r     <= '0;
      removed_r  <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_step & scan_more;
      if (cmd.push) begin
        oldest_r <= full ? oldest_inc : oldest_r;
        held_r   <= full ? held_r : held_r + 1'b1;
      end
      if (cmd.capture && (mode_r == MODE_POP)) begin
        oldest_r <= oldest_inc;
        held_r   <= held_r - 1'b1;
      end
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        kept_r     <= '0;
        removed_r  <= '0;
      end else begin
        if (cmd.scan_step && scan_more) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (key_match) begin
            removed_r <= removed_r + 1'b1;
          end else begin
            kept_r <= kept_r + 1'b1;
          end
        end
      end
      if (cmd.commit) begin
        acc_r <= acc_sat;
        if (removed_r != '0) begin
          bank_r   <= ~bank_r;
          oldest_r <= '0;
          held_r   <= kept_r;
        end
      end
      if (cmd.emit && (mode_r == MODE_PURGE) && last_r) begin
        acc_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r       <= in_mode;
      key_r        <= in_event_key;
      pay_r        <= in_event_payload[PAYLOAD_BITS-1:0];
      idx_r        <= in_peek_index;
      last_r       <= in_last_key;
      res_status_r <= 1'b0;
      res_key_r    <= '0;
      res_pay_r    <= '0;
    end
    if (cmd.set_err) begin
      res_status_r <= 1'b1;
    end
    if (cmd.capture) begin
      res_key_r <= rdata_r[WW-1 -: KEY_W];
      res_pay_r <= rdata_r[PAYLOAD_BITS-1:0];
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_pay_r    <= PAY_W'(res_pay_r);
      out_total_r  <= CNT_W'(acc_r);
      out_fill_r   <= CNT_W'(held_r);
    end
  end

  always_comb begin
    sts.mode       = mode_r;
    sts.item_ok    = item_ok;
    sts.scan_more  = scan_more;
    sts.rd_pending = rd_vld_r;
  end

  assign out_status        = out_status_r;
  assign out_key           = out_key_r;
  assign out_payload       = out_pay_r;
  assign out_removed_total = out_total_r;
  assign out_fill_count    = out_fill_r;

  `ORQ_ASSERT(a_held_bound, held_r <= CW'(CAPACITY), "Held count exceeds capacity.")
  `ORQ_ASSERT(a_acc_bound, acc_r <= CW'(CAPACITY), "Purge total exceeds capacity.")
  `ORQ_ASSERT(a_scan_tally, ((CW + 1)'(kept_r) + (CW + 1)'(removed_r) + (CW + 1)'(rd_vld_r)) == (CW + 1)'(scan_idx_r), "Purge scan lost an entry.")

endmodule

/* rtl/core/orq_ctrl.sv */
// Controller state machine of the ring queue: sequences each request and the output register.
`include "overwrite_ring_queue_with_key_purge_core_macros.svh"
module orq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  orq_pkg::orq_sts_t sts,
  output orq_pkg::orq_cmd_t cmd
);
  import orq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_SCAN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.mode)
          MODE_PUSH: begin
            cmd.push  = 1'b1;
            state_nxt = S_EMIT;
          end
          MODE_POP, MODE_FRONT, MODE_PEEK: begin
            if (sts.item_ok) begin
              cmd.rd_item = 1'b1;
              state_nxt   = S_READ;
            end else begin
              cmd.set_err = 1'b1;
              state_nxt   = S_EMIT;
            end
          end
          MODE_PURGE: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          default: begin
            cmd.set_err = 1'b1;
            state_nxt   = S_EMIT;
          end
        endcase
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_nxt   = S_EMIT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (!sts.scan_more && !sts.rd_pending) begin
          cmd.commit = 1'b1;
          state_nxt  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `ORQ_IMPLY(a_emit_free, cmd.emit, !out_valid_r || out_ready, "Result overwrote an untaken one.")
  `ORQ_IMPLY(a_commit_drained, cmd.commit, !sts.rd_pending && !sts.scan_more, "Purge committed early.")
  `ORQ_IMPLY(a_pending_in_scan, sts.rd_pending, state_r == S_SCAN, "Scan read outside purge.")

endmodule

/* rtl/core/overwrite_ring_queue_with_key_purge_core.sv */
// Top level of the overwrite-oldest ring queue with purge by key.
// Usage: a request enters on in_valid/in_ready with its mode, key, payload,
// peek index and last-key flag; exactly one result leaves on
// out_valid/out_ready for each request, in request order.
// Push, pop, front and peek on an empty queue, unused modes and out-of-range
// peeks go from the execute state straight to the emit state; successful pop,
// front and peek also pass the read state: the event memory read is registered.
// A purge walks every held event through the single memory read port, one per
// cycle, and commits once the scan and its last read have drained.
// The block works on one request at a time: in_ready rises again on the cycle
// after the result is loaded into the output register.
// When the receiver stalls, the waiting result stays in the output register,
// the next request is still accepted and processed, and its result is held
// internally until the output register is free.
// Reset empties the queue and clears the running purge total; no memory
// clearing pass is needed.
module overwrite_ring_queue_with_key_purge_core #(
  parameter int CAPACITY     = orq_pkg::DEF_CAPACITY,
  parameter int PAYLOAD_BITS = orq_pkg::DEF_PAYLOAD_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [orq_pkg::MODE_W-1:0] in_mode,
  input  logic [orq_pkg::KEY_W-1:0]  in_event_key,
  input  logic [orq_pkg::PAY_W-1:0]  in_event_payload,
  input  logic [orq_pkg::IDX_W-1:0]  in_peek_index,
  input  logic                       in_last_key,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_status,
  output logic [orq_pkg::KEY_W-1:0]  out_key,
  output logic [orq_pkg::PAY_W-1:0]  out_payload,
  output logic [orq_pkg::CNT_W-1:0]  out_removed_total,
  output logic [orq_pkg::CNT_W-1:0]  out_fill_count
);
  import orq_pkg::*;

  orq_cmd_t cmd;
  orq_sts_t sts;

  orq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  orq_datapath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_event_key      (in_event_key),
    .in_event_payload  (in_event_payload),
    .in_peek_index     (in_peek_index),
    .in_last_key       (in_last_key),
    .out_status        (out_status),
    .out_key           (out_key),
    .out_payload       (out_payload),
    .out_removed_total (out_removed_total),
    .out_fill_count    (out_fill_count)
  );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the overwrite-oldest event ring queue with purge by key.
`timescale 1ns / 1ps

module tb;
  import orq_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_W'(MODE_PURGE + 1);
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = '1;

  typedef struct packed {
    logic             status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [CNT_W-1:0] removed;
    logic [CNT_W-1:0] fill;
  } queue_reply_t;

  class event_ring_tracker;
    logic [KEY_W-1:0] key_mem[CAP];
    logic [PAY_W-1:0] pay_mem[CAP];
    int oldest;
    int held;
    int purge_sum;
    queue_reply_t due_replies[$];
    int mismatches;
    int strays;
    int checked;
    int requests;
    int purges;
    int overwrites;
    int errors;

    function int drop_key(logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] nk[CAP];
      logic [PAY_W-1:0] np[CAP];
      int kept;
      int gone;
      int s;
      kept = 0;
      gone = 0;
      for (int i = 0; i < held; i++) begin
        s = (oldest + i) % CAP;
        if (key_mem[s] == key) begin
          gone++;
        end else begin
          nk[kept] = key_mem[s];
          np[kept] = pay_mem[s];
          kept++;
        end
      end
      if (gone != 0) begin
        for (int i = 0; i < kept; i++) begin
          key_mem[i] = nk[i];
          pay_mem[i] = np[i];
        end
        oldest = 0;
        held = kept;
      end
      return gone;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic [PAY_W-1:0] pay, logic [IDX_W-1:0] idx, logic last);
      queue_reply_t r;
      int s;
      bit clear_after;
      r = '0;
      clear_after = 0;
      requests++;
      case (mode)
        MODE_PUSH: begin
          if (held >= CAP) begin
            oldest = (oldest + 1) % CAP;
            held = CAP - 1;
            overwrites++;
          end
          s = (oldest + held) % CAP;
          key_mem[s] = key;
          pay_mem[s] = pay;
          held++;
        end
        MODE_POP, MODE_FRONT: begin
          if (held == 0) begin
            r.status = 1'b1;
          end else begin
            r.key = key_mem[oldest];
            r.payload = pay_mem[oldest];
            if (mode == MODE_POP) begin
              oldest = (oldest + 1) % CAP;
              held--;
            end
          end
        end
        MODE_PEEK: begin
          if (int'(idx) >= held) begin
            r.status = 1'b1;
          end else begin
            s = (oldest + int'(idx)) % CAP;
            r.key = key_mem[s];
            r.payload = pay_mem[s];
          end
        end
        MODE_PURGE: begin
          purges++;
          purge_sum += drop_key(key);
          if (purge_sum > CAP) purge_sum = CAP;
          clear_after = last;
        end
        default: begin
          r.status = 1'b1;
        end
      endcase
      if (r.status) errors++;
      r.removed = CNT_W'(purge_sum);
      r.fill = CNT_W'(held);
      if (clear_after) purge_sum = 0;
      due_replies.push_back(r);
    endfunction

    function void check_result(queue_reply_t got);
      queue_reply_t want;
      if (due_replies.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10)
          $display("unexpected reply: status=%0d key=%h payload=%h removed=%0d fill=%0d",
                   got.status, got.key, got.payload, got.removed, got.fill);
        return;
      end
      want = due_replies.pop_front();
      checked++;
      if (got.status !== want.status || got.key !== want.key ||
          got.payload !== want.payload || got.removed !== want.removed ||
          got.fill !== want.fill) begin
        mismatches++;
        if (mismatches + strays <= 10) begin
          $display("reply %0d: expected status=%0d key=%h payload=%h removed=%0d fill=%0d,",
                   checked, want.status, want.key, want.payload, want.removed, want.fill);
          $display("  got status=%0d key=%h payload=%h removed=%0d fill=%0d",
                   got.status, got.key, got.payload, got.removed, got.fill);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MODE_W-1:0] in_mode = MODE_PUSH;
  logic [KEY_W-1:0] in_event_key = '0;
  logic [PAY_W-1:0] in_event_payload = '0;
  logic [IDX_W-1:0] in_peek_index = '0;
  logic in_last_key = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_status;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  logic [CNT_W-1:0] out_removed_total;
  logic [CNT_W-1:0] out_fill_count;

  bit calm = 0;
  logic [KEY_W-1:0] key_pool[4];
  event_ring_tracker sb = new();

  overwrite_ring_queue_with_key_purge_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_mode(in_mode),
    .in_event_key(in_event_key),
    .in_event_payload(in_event_payload),
    .in_peek_index(in_peek_index),
    .in_last_key(in_last_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_key(out_key),
    .out_payload(out_payload),
    .out_removed_total(out_removed_total),
    .out_fill_count(out_fill_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_req(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                          input logic [PAY_W-1:0] pay, input logic [IDX_W-1:0] idx,
                          input logic last);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_event_key <= key;
    in_event_payload <= pay;
    in_peek_index <= idx;
    in_last_key <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(mode, key, pay, idx, last);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.due_replies.size() != 0);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 75) return key_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  task automatic send_purge_list();
    int n;
    n = $urandom_range(1, 3);
    for (int j = 0; j < n; j++) begin
      send_req(MODE_PURGE, pick_key(), $urandom, IDX_W'($urandom), (j == n - 1));
      if (j < n - 1 && $urandom_range(99) < 20)
        send_req(MODE_PUSH, pick_key(), $urandom, IDX_W'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result('{out_status, out_key, out_payload, out_removed_total, out_fill_count});
      out_ready <= calm || $urandom_range(99) >= 6;
    end
  end

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int sent;
    int r;
    logic [IDX_W-1:0] idx;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = $urandom;
    key_pool[3] = $urandom;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_req(MODE_POP, $urandom, $urandom, '0, 1'b0);
    send_req(MODE_PEEK, $urandom, $urandom, '0, 1'b1);
    send_req(MODE_SPARE_LO, $urandom, $urandom, '0, 1'b0);
    send_req(MODE_PUSH, '0, '1, '1, 1'b1);
    for (int i = 0; i < CAP; i++) send_req(MODE_PUSH, '1, PAY_W'(i), '0, 1'b0);
    send_req(MODE_PEEK, '0, '0, IDX_W'(CAP - 1), 1'b0);
    send_req(MODE_FRONT, '0, '0, '0, 1'b0);
    send_req(MODE_PURGE, '1, '0, '0, 1'b0);
    send_req(MODE_PUSH, '1, '0, '0, 1'b0);
    send_req(MODE_PURGE, '1, '0, '0, 1'b1);
    drain();

    sent = 0;
    while (sent < 600) begin
      calm = (sent >= 250 && sent < 400);
      if (sent % 150 == 149) drain();
      if ($urandom_range(99) < 5) key_pool[$urandom_range(2, 3)] = $urandom;
      r = $urandom_range(99);
      idx = IDX_W'($urandom);
      if (sb.held > 0 && $urandom_range(99) < 70) idx = IDX_W'($urandom_range(sb.held - 1));
      if (r < 40)
        send_req(MODE_PUSH, pick_key(), $urandom, IDX_W'($urandom), 1'($urandom_range(1)));
      else if (r < 52)
        send_req(MODE_POP, $urandom, $urandom, IDX_W'($urandom), 1'($urandom_range(1)));
      else if (r < 60)
        send_req(MODE_FRONT, $urandom, $urandom, IDX_W'($urandom), 1'($urandom_range(1)));
      else if (r < 75)
        send_req(MODE_PEEK, $urandom, $urandom, idx, 1'($urandom_range(1)));
      else if (r < 95)
        send_purge_list();
      else if (r < 98)
        send_req(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), $urandom, $urandom,
                 IDX_W'($urandom), 1'($urandom_range(1)));
      else
        send_req(MODE_PURGE, pick_key(), $urandom, IDX_W'($urandom), 1'($urandom_range(1)));
      sent = sb.requests;
    end
    calm = 0;

    drain();
    repeat (40) @(posedge clk);
    $display("Run covered %0d requests: %0d purge keys, %0d overwrites, %0d error replies.",
             sb.requests, sb.purges, sb.overwrites, sb.errors);
    $display("%0d replies checked, %0d mismatches, %0d unexpected replies.",
             sb.checked, sb.mismatches, sb.strays);
    if (sb.mismatches == 0 && sb.strays == 0 && sb.due_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
